[sv/rrf_pkg.sv]
// shared types and constants for the rotor ring action and force block
package rrf_pkg;

  localparam int ANGLE_W    = 16;
  localparam int COUPLING_W = 24;
  localparam int SITE_W     = 12;
  localparam int FORCE_W    = 26;
  localparam int ACTION_W   = 37;
  localparam int TRIG_W     = 18;
  localparam int MAG_W      = 17;

  localparam logic [COUPLING_W-1:0] COUPLING_RESET = 24'd65536;
  localparam logic [ANGLE_W-1:0]    QUARTER_TURN   = 16'd16384;
  localparam longint unsigned       HALF_PI_Q30    = 64'd1686629713;

  typedef enum logic [1:0] {
    KIND_FORCE  = 2'd0,
    KIND_ACTION = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic              emit;
    logic              add_cos;
    logic              clear;
    logic              last;
    logic [SITE_W-1:0] site;
  } job_ctrl_t;

endpackage

[sv/rotor_ring_action_and_force_core.sv]
// top level of the rotor ring action and force block
//
// in channel: one word per site, in_angle (65536 = one turn) and in_last_site
// marking the final site. out channel: one word per result, out_kind tells a
// site force, the ring action or a too-few-sites error; out_end_of_run marks
// the last word caused by an input word.
// cfg channel: cfg_coupling sets beta (16 fraction bits), always ready; write
// it only while no input word is in flight.
// a result passes the job register, stages s2 (table read), s3 and s4, then the output register.
// throughput: one input word per cycle while the ring is open and the output
// does not stall; the word that closes a ring holds the job sequencer for its
// steps (force, last force, site 0 force, action), as the output gives one
// result per cycle: one sine table read pair and one cosine read each.
// reset (synchronous, rst_n low) clears the ring state and sets beta to 1.0.
// a stalled receiver holds the output register; the pipeline keeps taking
// words until its stages fill, then in_ready drops.
module rotor_ring_action_and_force_core #(
  parameter int MAX_SITES   = 4096,
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rrf_pkg::COUPLING_W-1:0]    cfg_coupling,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rrf_pkg::ANGLE_W-1:0]       in_angle,
  input  logic                              in_last_site,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_kind,
  output logic [rrf_pkg::SITE_W-1:0]        out_site,
  output logic signed [rrf_pkg::FORCE_W-1:0] out_force_value,
  output logic [rrf_pkg::ACTION_W-1:0]      out_action_value,
  output logic                              out_end_of_run
);
  import rrf_pkg::*;

  logic [COUPLING_W-1:0] coupling_r;

  logic               job_valid;
  logic               job_ready;
  job_ctrl_t          job_ctrl;
  logic [ANGLE_W-1:0] sin_angle_a, sin_angle_b, cos_angle_w;
  logic               rom_en;

  logic [ANGLE_W-1:0]       sin_ang [2];
  logic [ANGLE_W-1:0]       cos_ang [1];
  logic signed [TRIG_W-1:0] sin_val [2];
  logic signed [TRIG_W-1:0] cos_val [1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coupling_r <= COUPLING_RESET;
    end else if (cfg_valid) begin
      coupling_r <= cfg_coupling;
    end
  end

  rrf_front #(
    .MAX_SITES(MAX_SITES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_angle    (in_angle),
    .in_last_site(in_last_site),
    .job_valid   (job_valid),
    .job_ready   (job_ready),
    .job_ctrl    (job_ctrl),
    .sin_angle_a (sin_angle_a),
    .sin_angle_b (sin_angle_b),
    .cos_angle   (cos_angle_w)
  );

  assign sin_ang[0] = sin_angle_a;
  assign sin_ang[1] = sin_angle_b;
  assign cos_ang[0] = cos_angle_w;

  rrf_sine_rom #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .NUM_RD     (2)
  ) u_sin_rom (
    .clk  (clk),
    .en   (rom_en),
    .angle(sin_ang),
    .value(sin_val)
  );

  rrf_sine_rom #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .NUM_RD     (1)
  ) u_cos_rom (
    .clk  (clk),
    .en   (rom_en),
    .angle(cos_ang),
    .value(cos_val)
  );

  rrf_back #(
    .MAX_SITES(MAX_SITES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (job_valid),
    .job_ready       (job_ready),
    .job_ctrl        (job_ctrl),
    .rom_en          (rom_en),
    .sin_val_a       (sin_val[0]),
    .sin_val_b       (sin_val[1]),
    .cos_val         (cos_val[0]),
    .coupling        (coupling_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_site        (out_site),
    .out_force_value (out_force_value),
    .out_action_value(out_action_value),
    .out_end_of_run  (out_end_of_run)
  );

endmodule

[sv/rrf_sine_rom.sv]
// quarter-wave sine table with angle decode and registered read ports
module rrf_sine_rom #(
  parameter int TABLE_DEPTH = 1024,
  parameter int NUM_RD      = 2
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [rrf_pkg::ANGLE_W-1:0]   angle [NUM_RD],
  output logic signed [rrf_pkg::TRIG_W-1:0] value [NUM_RD]
);
  import rrf_pkg::*;

  localparam int AW     = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_PW = 14 + AW;
  localparam longint unsigned TaylorDiv [1:8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  function automatic logic [MAG_W-1:0] sine_entry(input int unsigned i);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    x    = (longint'(i) * HALF_PI_Q30) / TABLE_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / TaylorDiv[k];
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    return MAG_W'((unsigned'(acc) + 64'd8192) >> 14);
  endfunction

  logic [MAG_W-1:0] rom_w [TABLE_DEPTH+1];

  for (genvar g = 0; g <= TABLE_DEPTH; g++) begin : g_rom
    assign rom_w[g] = sine_entry(g);
  end

  for (genvar p = 0; p < NUM_RD; p++) begin : g_port
    logic [IDX_PW-1:0] prod;
    logic [AW-1:0]     idx;
    logic [AW-1:0]     addr;
    logic [MAG_W-1:0]  mag_r;
    logic              neg_r;

    assign prod = IDX_PW'(angle[p][13:0]) * IDX_PW'(TABLE_DEPTH);
    assign idx  = AW'(prod >> 14);
    assign addr = angle[p][14] ? (AW'(TABLE_DEPTH) - idx) : idx;

    always_ff @(posedge clk) begin
      if (en) begin
        mag_r <= rom_w[addr];
        neg_r <= angle[p][15];
      end
    end

    assign value[p] = neg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
  end

endmodule

[sv/rrf_front.sv]
// lattice state, word register and per-result job sequencing
module rrf_front #(
  parameter int MAX_SITES = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rrf_pkg::ANGLE_W-1:0] in_angle,
  input  logic                        in_last_site,
  output logic                        job_valid,
  input  logic                        job_ready,
  output rrf_pkg::job_ctrl_t          job_ctrl,
  output logic [rrf_pkg::ANGLE_W-1:0] sin_angle_a,
  output logic [rrf_pkg::ANGLE_W-1:0] sin_angle_b,
  output logic [rrf_pkg::ANGLE_W-1:0] cos_angle
);
  import rrf_pkg::*;

  localparam int CNT_W = $clog2(MAX_SITES);

  typedef enum logic [3:0] {
    STEP_PRIOR  = 4'b0001,
    STEP_LAST   = 4'b0010,
    STEP_FIRST  = 4'b0100,
    STEP_ACTION = 4'b1000
  } step_t;

  logic [ANGLE_W-1:0] first_r, second_r, older_r, newest_r;
  logic [CNT_W-1:0]   cnt_r;

  logic               ex_v_r;
  logic [ANGLE_W-1:0] ex_a_r, ex_first_r, ex_second_r, ex_older_r, ex_newest_r;
  logic [CNT_W-1:0]   ex_k_r;
  logic               ex_close_r;
  step_t              step_r, step_nxt;

  logic accept;
  logic close;
  logic has_job;
  logic ex_last_step;
  logic ex_short;

  assign close   = in_last_site || (cnt_r == CNT_W'(MAX_SITES - 1));
  assign has_job = close || (cnt_r != '0);
  assign ex_short = ex_k_r < CNT_W'(2);
  assign ex_last_step = !ex_close_r || ex_short || (step_r == STEP_ACTION);
  assign in_ready = !ex_v_r || (job_ready && ex_last_step);
  assign accept   = in_valid && in_ready;
  assign job_valid = ex_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= '0;
      second_r <= '0;
      older_r  <= '0;
      newest_r <= '0;
      cnt_r    <= '0;
    end else if (accept) begin
      if (close) begin
        first_r  <= '0;
        second_r <= '0;
        older_r  <= '0;
        newest_r <= '0;
        cnt_r    <= '0;
      end else begin
        if (cnt_r == CNT_W'(0)) begin
          first_r <= in_angle;
        end
        if (cnt_r == CNT_W'(1)) begin
          second_r <= in_angle;
        end
        older_r  <= newest_r;
        newest_r <= in_angle;
        cnt_r    <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    case (step_r)
      STEP_PRIOR:  step_nxt = STEP_LAST;
      STEP_LAST:   step_nxt = STEP_FIRST;
      STEP_FIRST:  step_nxt = STEP_ACTION;
      default:     step_nxt = STEP_PRIOR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_v_r <= 1'b0;
      step_r <= STEP_PRIOR;
    end else if (accept) begin
      ex_v_r <= has_job;
      step_r <= STEP_PRIOR;
    end else if (ex_v_r && job_ready) begin
      if (ex_last_step) begin
        ex_v_r <= 1'b0;
      end else begin
        step_r <= step_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ex_a_r      <= in_angle;
      ex_first_r  <= first_r;
      ex_second_r <= second_r;
      ex_older_r  <= older_r;
      ex_newest_r <= newest_r;
      ex_k_r      <= cnt_r;
      ex_close_r  <= close;
    end
  end

  // job for the current step: sine angles, cosine angle and control
  always_comb begin
    job_ctrl         = '0;
    job_ctrl.kind    = KIND_FORCE;
    sin_angle_a      = ex_newest_r - ex_older_r;
    sin_angle_b      = ex_newest_r - ex_a_r;
    cos_angle        = ex_a_r - ex_newest_r + QUARTER_TURN;
    job_ctrl.site    = SITE_W'(ex_k_r - CNT_W'(1));
    job_ctrl.add_cos = 1'b1;
    job_ctrl.emit    = !ex_short;
    job_ctrl.last    = !ex_close_r;
    if (ex_close_r && ex_short) begin
      job_ctrl.kind    = KIND_ERROR;
      job_ctrl.site    = '0;
      job_ctrl.add_cos = 1'b0;
      job_ctrl.clear   = 1'b1;
      job_ctrl.emit    = 1'b1;
      job_ctrl.last    = 1'b1;
    end else if (ex_close_r) begin
      case (step_r)
        STEP_PRIOR: begin
          job_ctrl.last = 1'b0;
        end
        STEP_LAST: begin
          sin_angle_a   = ex_a_r - ex_newest_r;
          sin_angle_b   = ex_a_r - ex_first_r;
          cos_angle     = ex_first_r - ex_a_r + QUARTER_TURN;
          job_ctrl.site = SITE_W'(ex_k_r);
          job_ctrl.last = 1'b0;
        end
        STEP_FIRST: begin
          sin_angle_a      = ex_first_r - ex_a_r;
          sin_angle_b      = ex_first_r - ex_second_r;
          job_ctrl.site    = '0;
          job_ctrl.add_cos = 1'b0;
          job_ctrl.last    = 1'b0;
        end
        default: begin
          job_ctrl.kind    = KIND_ACTION;
          job_ctrl.site    = '0;
          job_ctrl.add_cos = 1'b0;
          job_ctrl.clear   = 1'b1;
          job_ctrl.last    = 1'b1;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_only_on_last_job: assert property (@(posedge clk) disable iff (!rst_n)
    ex_v_r && in_ready |-> ex_last_step)
    else $error("new word taken before the pending jobs are issued");

  a_close_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && close |=> cnt_r == '0)
    else $error("site count not cleared after a closing word");

  a_steps_only_when_closing: assert property (@(posedge clk) disable iff (!rst_n)
    ex_v_r && step_r != STEP_PRIOR |-> ex_close_r)
    else $error("extra job step on a word that does not close the ring");
`endif

endmodule

[sv/rrf_back.sv]
// cosine accumulation, coupling multiply, rounding and output register
module rrf_back #(
  parameter int MAX_SITES = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              job_valid,
  output logic                              job_ready,
  input  rrf_pkg::job_ctrl_t                job_ctrl,
  output logic                              rom_en,
  input  logic signed [rrf_pkg::TRIG_W-1:0] sin_val_a,
  input  logic signed [rrf_pkg::TRIG_W-1:0] sin_val_b,
  input  logic signed [rrf_pkg::TRIG_W-1:0] cos_val,
  input  logic [rrf_pkg::COUPLING_W-1:0]    coupling,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_kind,
  output logic [rrf_pkg::SITE_W-1:0]        out_site,
  output logic signed [rrf_pkg::FORCE_W-1:0] out_force_value,
  output logic [rrf_pkg::ACTION_W-1:0]      out_action_value,
  output logic                              out_end_of_run
);
  import rrf_pkg::*;

  localparam int CNT_W  = $clog2(MAX_SITES);
  localparam int SUM_W  = CNT_W + TRIG_W;
  localparam int OP_W   = SUM_W + 1;
  localparam int PROD_W = OP_W + COUPLING_W + 1;
  localparam int PAIR_W = TRIG_W + 1;

  logic      s2_v_r, s3_v_r, s4_v_r, out_v_r;
  job_ctrl_t s2_ctrl_r, s3_ctrl_r, s4_ctrl_r;
  logic      s2_free, s3_free, s4_free, out_free;

  logic [SUM_W-1:0]         sum_r;
  logic signed [OP_W-1:0]   op_r, op_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PAIR_W-1:0] pair_sum;
  logic [TRIG_W-1:0]        cos_term;
  logic signed [PROD_W-1:0] rnd;
  logic signed [PROD_W-1:0] scaled;

  logic [1:0]                kind_r;
  logic [SITE_W-1:0]         site_r;
  logic signed [FORCE_W-1:0] force_r;
  logic [ACTION_W-1:0]       action_r;
  logic                      end_r;

  assign out_free  = !out_v_r || out_ready;
  assign s4_free   = !s4_v_r || out_free;
  assign s3_free   = !s3_v_r || s4_free;
  assign s2_free   = !s2_v_r || s3_free;
  assign job_ready = s2_free;
  assign rom_en    = s2_free;

  assign pair_sum = PAIR_W'(sin_val_a) + PAIR_W'(sin_val_b);
  assign cos_term = TRIG_W'(PAIR_W'(signed'(19'sd65536)) - PAIR_W'(cos_val));

  always_comb begin
    case (s2_ctrl_r.kind)
      KIND_FORCE:  op_nxt = OP_W'(pair_sum);
      KIND_ACTION: op_nxt = signed'({1'b0, sum_r});
      default:     op_nxt = '0;
    endcase
  end

  // ties away from zero for forces, ties up for the action
  assign rnd    = prod_r + PROD_W'(32768) - PROD_W'(prod_r[PROD_W-1]);
  assign scaled = rnd >>> 16;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      sum_r   <= '0;
    end else begin
      if (s2_free) begin
        s2_v_r <= job_valid;
      end
      if (s3_free) begin
        s3_v_r <= s2_v_r && s2_ctrl_r.emit;
        if (s2_v_r) begin
          if (s2_ctrl_r.clear) begin
            sum_r <= '0;
          end else if (s2_ctrl_r.add_cos) begin
            sum_r <= sum_r + SUM_W'(cos_term);
          end
        end
      end
      if (s4_free) begin
        s4_v_r <= s3_v_r;
      end
      if (out_free) begin
        out_v_r <= s4_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_ctrl_r <= job_ctrl;
    end
    if (s3_free) begin
      s3_ctrl_r <= s2_ctrl_r;
      op_r      <= op_nxt;
    end
    if (s4_free) begin
      s4_ctrl_r <= s3_ctrl_r;
      prod_r    <= PROD_W'(signed'({1'b0, coupling}) * op_r);
    end
    if (out_free) begin
      kind_r <= s4_ctrl_r.kind;
      end_r  <= s4_ctrl_r.last;
      case (s4_ctrl_r.kind)
        KIND_FORCE: begin
          site_r   <= s4_ctrl_r.site;
          force_r  <= FORCE_W'(scaled);
          action_r <= '0;
        end
        KIND_ACTION: begin
          site_r   <= '0;
          force_r  <= '0;
          action_r <= ACTION_W'(scaled);
        end
        default: begin
          site_r   <= '0;
          force_r  <= '0;
          action_r <= '0;
        end
      endcase
    end
  end

  assign out_valid        = out_v_r;
  assign out_kind         = kind_r;
  assign out_site         = site_r;
  assign out_force_value  = force_r;
  assign out_action_value = action_r;
  assign out_end_of_run   = end_r;

`ifndef SYNTHESIS
  a_ring_result_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_ACTION || out_kind == KIND_ERROR) |-> out_end_of_run)
    else $error("action or error word not marked as end of run");

  a_action_has_no_force: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ACTION |-> out_force_value == '0 && out_site == '0)
    else $error("action word carries force fields");

  a_clear_empties_sum: assert property (@(posedge clk) disable iff (!rst_n)
    s3_free && s2_v_r && s2_ctrl_r.clear |=> sum_r == '0)
    else $error("cosine sum not cleared at end of ring");
`endif

endmodule

[dv/rotor_ring_action_and_force_core_tb.sv]
// self-checking testbench for the rotor ring action and force block
`timescale 1ns / 1ps

module rotor_ring_action_and_force_core_tb;
  import rrf_pkg::*;

  localparam int RING_MAX_SITES = 4096;
  localparam int ROM_DEPTH      = 1024;
  localparam int STALL_LIMIT    = 20000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_SITES   = 175;
  localparam int TABLE_ROWS     = 29;
  localparam int ONE_Q16        = 65536;

  typedef enum logic {ROW_SITE, ROW_COUPLING} row_op_t;
  typedef enum logic [1:0] {
    OUT_MODEL, OUT_NONE, OUT_ERROR, OUT_QUIET_RING
  } outcome_t;

  typedef struct packed {
    row_op_t         op;
    logic [23:0]     value;
    logic            last;
    outcome_t        how;
  } row_t;

  typedef struct packed {
    kind_t                 kind;
    logic [SITE_W-1:0]     site;
    logic [FORCE_W-1:0]    force_val;
    logic [ACTION_W-1:0]   action;
    logic                  eor;
  } ring_result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [COUPLING_W-1:0]   cfg_coupling;
  logic                    in_valid;
  logic                    in_ready;
  logic [ANGLE_W-1:0]      in_angle;
  logic                    in_last_site;
  logic                    out_valid;
  logic                    out_ready;
  logic [1:0]              out_kind;
  logic [SITE_W-1:0]       out_site;
  logic signed [FORCE_W-1:0] out_force_value;
  logic [ACTION_W-1:0]     out_action_value;
  logic                    out_end_of_run;

  rotor_ring_action_and_force_core #(
    .MAX_SITES  (RING_MAX_SITES),
    .TABLE_DEPTH(ROM_DEPTH)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_coupling    (cfg_coupling),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_angle        (in_angle),
    .in_last_site    (in_last_site),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_site        (out_site),
    .out_force_value (out_force_value),
    .out_action_value(out_action_value),
    .out_end_of_run  (out_end_of_run)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ring predictor state
  int unsigned       sine_rom [0:ROM_DEPTH];
  logic [15:0]       ring_first;
  logic [15:0]       ring_second;
  logic [15:0]       ring_older;
  logic [15:0]       ring_newest;
  int unsigned       ring_count;
  longint unsigned   ring_cos_sum;
  logic [23:0]       ring_coupling;

  ring_result_t      fresh_results[$];
  ring_result_t      expected_ring_results[$];

  int  fail_count;
  int  sites_sent;
  int  cfg_writes;
  int  forces_checked;
  int  actions_checked;
  int  errors_checked;
  bit  quiet_phase;
  bit  hold_request;

  function automatic void build_sine_rom();
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    for (int i = 0; i <= ROM_DEPTH; i++) begin
      x = (longint'(i) * HALF_PI_Q30) / ROM_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      acc = longint'(x);
      for (int k = 1; k <= 8; k++) begin
        term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          acc -= longint'(term);
        end else begin
          acc += longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      sine_rom[i] = int'((longint'(acc) + 8192) >> 14);
    end
  endfunction

  function automatic int trig_sin(logic [15:0] a);
    logic [1:0]  quad;
    logic [13:0] off;
    int          idx;
    int          mag;
    quad = a[15:14];
    off = a[13:0];
    idx = int'((longint'(off) * ROM_DEPTH) >> 14);
    if (idx > ROM_DEPTH) begin
      idx = ROM_DEPTH;
    end
    mag = quad[0] ? sine_rom[ROM_DEPTH - idx] : sine_rom[idx];
    return quad[1] ? -mag : mag;
  endfunction

  function automatic int trig_cos(logic [15:0] a);
    logic [15:0] shifted;
    shifted = a + QUARTER_TURN;
    return trig_sin(shifted);
  endfunction

  function automatic logic [FORCE_W-1:0] site_force_of(logic [15:0] left, logic [15:0] mid,
                                                       logic [15:0] right);
    logic [15:0]     d_left;
    logic [15:0]     d_right;
    longint          sum;
    longint          prod;
    longint unsigned mag;
    longint unsigned rounded;
    d_left = mid - left;
    d_right = mid - right;
    sum = longint'(trig_sin(d_left)) + longint'(trig_sin(d_right));
    prod = longint'(ring_coupling) * sum;
    mag = (prod < 0) ? -prod : prod;
    rounded = (mag + 32768) >> 16;
    return FORCE_W'((prod < 0) ? (64'd0 - rounded) : rounded);
  endfunction

  function automatic void clear_ring();
    ring_first = '0;
    ring_second = '0;
    ring_older = '0;
    ring_newest = '0;
    ring_count = 0;
    ring_cos_sum = 0;
  endfunction

  function automatic void add_fresh(kind_t k, logic [SITE_W-1:0] s, logic [FORCE_W-1:0] f,
                                    logic [ACTION_W-1:0] act);
    ring_result_t r;
    r.kind = k;
    r.site = s;
    r.force_val = f;
    r.action = act;
    r.eor = 1'b0;
    fresh_results.push_back(r);
  endfunction

  function automatic void predict_site(logic [15:0] a, logic last);
    int unsigned     k;
    logic [15:0]     d;
    longint unsigned act;
    ring_result_t    r;
    k = ring_count;
    fresh_results.delete();
    if (k >= 1) begin
      d = a - ring_newest;
      ring_cos_sum += longint'(ONE_Q16 - trig_cos(d));
    end
    if (k >= 2) begin
      add_fresh(KIND_FORCE, SITE_W'(k - 1), site_force_of(ring_older, ring_newest, a), '0);
    end
    if (k == 0) begin
      ring_first = a;
    end
    if (k == 1) begin
      ring_second = a;
    end
    if (last || (k + 1 >= RING_MAX_SITES)) begin
      if (k < 2) begin
        add_fresh(KIND_ERROR, '0, '0, '0);
      end else begin
        add_fresh(KIND_FORCE, SITE_W'(k), site_force_of(ring_newest, a, ring_first), '0);
        add_fresh(KIND_FORCE, '0, site_force_of(a, ring_first, ring_second), '0);
        d = ring_first - a;
        ring_cos_sum += longint'(ONE_Q16 - trig_cos(d));
        act = (longint'(ring_coupling) * ring_cos_sum + 32768) >> 16;
        add_fresh(KIND_ACTION, '0, '0, ACTION_W'(act));
      end
      clear_ring();
    end else begin
      ring_older = ring_newest;
      ring_newest = a;
      ring_count = k + 1;
    end
    if (fresh_results.size() > 0) begin
      r = fresh_results.pop_back();
      r.eor = 1'b1;
      fresh_results.push_back(r);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [23:0] pick_coupling();
    case ($urandom_range(0, 5))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return COUPLING_RESET;
      3: return 24'($urandom_range(0, 255));
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] next_angle(int style, logic [15:0] prev);
    logic [15:0] corner;
    case (style)
      1: return prev + 16'($urandom_range(0, 1200)) - 16'd600;
      2: begin
        case ($urandom_range(0, 7))
          0: corner = 16'h0000;
          1: corner = 16'hFFFF;
          2: corner = 16'h3FFF;
          3: corner = 16'h4000;
          4: corner = 16'h7FFF;
          5: corner = 16'h8000;
          6: corner = 16'hBFFF;
          default: corner = 16'hC000;
        endcase
        return corner + 16'($urandom_range(0, 2)) - 16'd1;
      end
      3: return prev + 16'h8000 + 16'($urandom_range(0, 64)) - 16'd32;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // let the block drain before touching the coupling register
  task automatic settle_ring();
    in_valid <= 1'b0;
    while (expected_ring_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_coupling(logic [23:0] v);
    settle_ring();
    cfg_coupling <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ring_coupling = v;
    cfg_writes++;
  endtask

  task automatic send_site(logic [15:0] a, logic last, outcome_t how);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_angle <= a;
    in_last_site <= last;
    do @(posedge clk); while (!in_ready);
    predict_site(a, last);
    sites_sent++;
    case (how)
      OUT_MODEL: begin
        foreach (fresh_results[i]) begin
          expected_ring_results.push_back(fresh_results[i]);
        end
      end
      OUT_ERROR: begin
        fresh_results.delete();
        add_fresh(KIND_ERROR, '0, '0, '0);
        expected_ring_results.push_back(fresh_results[0]);
        expected_ring_results[expected_ring_results.size() - 1].eor = 1'b1;
      end
      OUT_QUIET_RING: begin
        fresh_results.delete();
        add_fresh(KIND_FORCE, 12'd1, '0, '0);
        add_fresh(KIND_FORCE, 12'd2, '0, '0);
        add_fresh(KIND_FORCE, 12'd0, '0, '0);
        add_fresh(KIND_ACTION, '0, '0, '0);
        foreach (fresh_results[i]) begin
          expected_ring_results.push_back(fresh_results[i]);
        end
        expected_ring_results[expected_ring_results.size() - 1].eor = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic send_ring(int len, int style);
    logic [15:0] a;
    a = 16'($urandom_range(0, 65535));
    for (int j = 0; j < len; j++) begin
      a = next_angle(style, a);
      if (j > 0 && j < len - 1 && len <= 40 && $urandom_range(0, 19) == 0) begin
        write_coupling(pick_coupling());
      end
      send_site(a, j == len - 1, OUT_MODEL);
    end
  endtask

  row_t stimulus_table [TABLE_ROWS] = '{
    '{ROW_SITE,     24'h000000, 1'b1, OUT_ERROR},
    '{ROW_SITE,     24'h001234, 1'b0, OUT_NONE},
    '{ROW_SITE,     24'h00FFFF, 1'b1, OUT_ERROR},
    '{ROW_SITE,     24'h000000, 1'b0, OUT_NONE},
    '{ROW_SITE,     24'h000000, 1'b0, OUT_NONE},
    '{ROW_SITE,     24'h000000, 1'b1, OUT_QUIET_RING},
    '{ROW_COUPLING, 24'hFFFFFF, 1'b0, OUT_NONE},
    '{ROW_SITE,     24'h00FFFF, 1'b0, OUT_NONE},
    '{ROW_SITE,     24'h00FFFF, 1'b0, OUT_NONE},
    '{ROW_SITE,     24'h00FFFF, 1'b1, OUT_QUIET_RING},
    '{ROW_SITE,     24'h000000, 1'b0, OUT_MODEL},
    '{ROW_SITE,     24'h00FFFF, 1'b0, OUT_MODEL},
    '{ROW_SITE,     24'h008000, 1'b0, OUT_MODEL},
    '{ROW_SITE,     24'h004000, 1'b0, OUT_MODEL},
    '{ROW_SITE,     24'h00C000, 1'b1, OUT_MODEL},
    '{ROW_COUPLING, 24'h000000, 1'b0, OUT_NONE},
    '{ROW_SITE,     24'h00FFFF, 1'b0, OUT_NONE},
    '{ROW_SITE,     24'h000000, 1'b0, OUT_NONE},
    '{ROW_SITE,     24'h003039, 1'b1, OUT_QUIET_RING},
    '{ROW_COUPLING, 24'h000001, 1'b0, OUT_NONE},
    '{ROW_SITE,     24'h008000, 1'b0, OUT_MODEL},
    '{ROW_SITE,     24'h000000, 1'b0, OUT_MODEL},
    '{ROW_SITE,     24'h008000, 1'b0, OUT_MODEL},
    '{ROW_SITE,     24'h000000, 1'b1, OUT_MODEL},
    '{ROW_COUPLING, 24'h010000, 1'b0, OUT_NONE},
    '{ROW_SITE,     24'h008000, 1'b0, OUT_MODEL},
    '{ROW_SITE,     24'h007FFF, 1'b0, OUT_MODEL},
    '{ROW_SITE,     24'h000001, 1'b0, OUT_MODEL},
    '{ROW_SITE,     24'h00FFFE, 1'b1, OUT_MODEL}
  };

  // receiver: random back-pressure, plus one long hold on request
  initial begin
    int gap;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    ring_result_t want;
    ring_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.kind = kind_t'(out_kind);
      got.site = out_site;
      got.force_val = out_force_value;
      got.action = out_action_value;
      got.eor = out_end_of_run;
      case (got.kind)
        KIND_FORCE:  forces_checked++;
        KIND_ACTION: actions_checked++;
        default:     errors_checked++;
      endcase
      if (expected_ring_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected word: kind %0d site %0d force %0d action %0d eor %0b",
                   got.kind, got.site, $signed(got.force_val), got.action, got.eor);
        end
      end else begin
        want = expected_ring_results.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch: expected kind %0d site %0d force %0d action %0d eor %0b",
                     want.kind, want.site, $signed(want.force_val), want.action, want.eor);
            $display("          actual   kind %0d site %0d force %0d action %0d eor %0b",
                     got.kind, got.site, $signed(got.force_val), got.action, got.eor);
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    int idle_cycles;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("rotor_ring_action_and_force_core_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int first_random;
    int r;
    int len;
    bit held;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_angle <= '0;
    in_last_site <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_coupling <= '0;
    fail_count = 0;
    sites_sent = 0;
    cfg_writes = 0;
    forces_checked = 0;
    actions_checked = 0;
    errors_checked = 0;
    quiet_phase = 1'b0;
    hold_request = 1'b0;
    held = 1'b0;
    build_sine_rom();
    ring_coupling = COUPLING_RESET;
    clear_ring();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stimulus_table[i]) begin
      if (stimulus_table[i].op == ROW_COUPLING) begin
        write_coupling(stimulus_table[i].value);
      end else begin
        send_site(stimulus_table[i].value[15:0], stimulus_table[i].last,
                  stimulus_table[i].how);
      end
    end

    first_random = sites_sent;
    while (sites_sent - first_random < RANDOM_SITES) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        write_coupling(pick_coupling());
      end
      quiet_phase = ($urandom_range(0, 3) == 0);
      if (!held && sites_sent - first_random > RANDOM_SITES / 3) begin
        // receiver stops while the sender streams, then sender waits it out
        held = 1'b1;
        quiet_phase = 1'b1;
        hold_request = 1'b1;
        send_ring(48, 0);
        quiet_phase = 1'b0;
        settle_ring();
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        len = $urandom_range(1, 2);
      end else if (r < 80) begin
        len = $urandom_range(3, 10);
      end else begin
        len = $urandom_range(11, 40);
      end
      send_ring(len, $urandom_range(0, 3));
    end
    quiet_phase = 1'b0;

    settle_ring();
    if (expected_ring_results.size() != 0) begin
      fail_count++;
    end
    $display("covered %0d site words and %0d coupling writes, short and long rings, long stall",
             sites_sent, cfg_writes);
    $display("checked %0d force, %0d action and %0d error words, %0d failures",
             forces_checked, actions_checked, errors_checked, fail_count);
    if (fail_count == 0) begin
      $display("rotor_ring_action_and_force_core_tb OK");
    end else begin
      $display("rotor_ring_action_and_force_core_tb NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/rrf_pkg.sv
sv/rrf_sine_rom.sv
sv/rrf_front.sv
sv/rrf_back.sv
sv/rotor_ring_action_and_force_core.sv
dv/rotor_ring_action_and_force_core_tb.sv
